// ===== hw/rtl/plfob_pkg.sv =====
// Package with the constants, codes and types of the price-level order book.
`default_nettype none
package plfob_pkg;
  localparam int NumLevels = 64;
  localparam int OrdersPerLevel = 16;
  localparam int MaxEvents = 16;
  localparam int LvlW = $clog2(NumLevels);
  localparam int SlotW = $clog2(OrdersPerLevel);
  localparam int CntW = $clog2(OrdersPerLevel + 1);
  localparam int EvW = $clog2(MaxEvents);
  localparam int EvCntW = $clog2(MaxEvents + 1);

  localparam logic [2:0] KindNew = 3'd0;
  localparam logic [2:0] KindChange = 3'd1;
  localparam logic [2:0] KindDelete = 3'd2;
  localparam logic [2:0] KindAdd = 3'd3;
  localparam logic [2:0] KindConsume = 3'd4;

  localparam logic [2:0] ResDelta = 3'd0;
  localparam logic [2:0] ResOrderId = 3'd1;
  localparam logic [2:0] ResEvent = 3'd2;
  localparam logic [2:0] ResNone = 3'd3;
  localparam logic [2:0] ResFull = 3'd4;

  typedef enum logic [2:0] {
    StIdle, StLook, StLvl, StOne, StCrd, StCuse, StCfin, StEmit
  } state_e;

  typedef struct packed {
    logic [31:0]     sum;
    logic [SlotW-1:0] head;
    logic [CntW-1:0]  cnt;
  } lvl_ent_t;

  typedef struct packed {
    logic [31:0] id;
    logic [31:0] qty;
  } slot_ent_t;
endpackage
`default_nettype wire

// ===== hw/rtl/price_level_fifo_order_book.sv =====
// Top level of the price-level order book with level and order memories.
//
// Input items arrive on in_valid_i/in_stall_o and are taken only while the
// block is idle; each item gives zero or more results on out_valid_o and
// out_stall_i, the final one marked by last_o. Results leave through an
// output register, so the next item is taken while the last result waits.
// A level update, delete, add order or consume at an absent price passes
// through the look-up, level and output states, and its result is loaded
// in the output state. A consume at a present price walks the queue instead,
// alternating a read and an update of the order memory for each order, then
// finishes the level and emits each event in turn from the emit state, or
// leaves through the output state when it touches no order.
// The price search compares all level keys at once and registers the match.
// Reset empties the table and sets the next order id to one; the memories
// need no clearing. A write on cfg_we_i loads the next order id. When the
// receiver stalls, the output register holds its item and the block waits.
`default_nettype none
module price_level_fifo_order_book import plfob_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic [31:0]        cfg_wdata_i,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire logic [2:0]         kind_i,
  input  wire logic [31:0]        price_i,
  input  wire logic [31:0]        qty_i,
  input  wire logic               event_type_i,
  input  wire logic [63:0]        exchange_ts_i,
  input  wire logic [63:0]        recv_ts_i,
  input  wire logic [63:0]        trade_id_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic [2:0]              result_kind_o,
  output logic signed [32:0]      delta_o,
  output logic [31:0]             order_id_o,
  output logic [31:0]             event_price_o,
  output logic [31:0]             event_qty_o,
  output logic                    event_kind_o,
  output logic [63:0]             event_exchange_ts_o,
  output logic [63:0]             event_recv_ts_o,
  output logic [63:0]             event_trade_id_o,
  output logic [31:0]             level_total_o,
  output logic                    level_present_o,
  output logic                    last_o
);
  state_e state_q, state_d;
  logic [NumLevels-1:0] valid_q, match_q, free_q;
  logic [31:0] key_q [NumLevels];
  logic [31:0] next_id_q;
  logic [2:0]  kind_q;
  logic [31:0] price_q, qty_q;
  logic        etype_q;
  logic [63:0] ets_q, rts_q, tid_q;

  lvl_ent_t  level_mem [NumLevels];
  slot_ent_t slot_mem [NumLevels*OrdersPerLevel];
  lvl_ent_t  lvl_rd;
  slot_ent_t slot_rd;

  logic            hit_q, avail_q;
  logic [LvlW-1:0] lvl_q;
  logic            hit_d, avail_d;
  logic [LvlW-1:0] hidx, fidx;

  logic [31:0]      sum_q, rem_q;
  logic [SlotW-1:0] head_q;
  logic [CntW-1:0]  cnt_q;
  logic [EvCntW-1:0] n_q;
  logic [EvW-1:0]   e_q;
  logic [31:0]      ev_id_q [MaxEvents];
  logic [31:0]      ev_qty_q [MaxEvents];

  logic [2:0]  res_kind_q;
  logic [32:0] res_delta_q;
  logic [31:0] res_oid_q, res_total_q;
  logic        res_present_q;

  logic        out_valid_q, out_free, out_load, accept;
  logic        cons_more, take_all;
  logic [31:0] lsum, taken, new_sum;
  logic [SlotW-1:0] lhead;
  logic [CntW-1:0]  lcnt;
  logic        q_full;

  assign accept = in_valid_i && !in_stall_o;
  assign out_free = !out_valid_q || !out_stall_i;
  assign out_valid_o = out_valid_q;

  always_comb begin
    hidx = '0;
    fidx = '0;
    hit_d = |match_q;
    avail_d = |free_q;
    for (int i = NumLevels - 1; i >= 0; i--) begin
      if (match_q[i]) hidx = LvlW'(i);
      if (free_q[i]) fidx = LvlW'(i);
    end
  end

  always_comb begin
    lsum = hit_q ? lvl_rd.sum : '0;
    lhead = hit_q ? lvl_rd.head : '0;
    lcnt = hit_q ? lvl_rd.cnt : '0;
    q_full = hit_q && (lcnt == CntW'(OrdersPerLevel));
    cons_more = (rem_q != '0) && (cnt_q != '0) && (n_q != EvCntW'(MaxEvents));
    take_all = slot_rd.qty <= rem_q;
    taken = qty_q - rem_q;
    new_sum = sum_q - taken;
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle: if (accept) state_d = StLook;
      StLook: state_d = StLvl;
      StLvl: begin
        if (kind_q > KindConsume) state_d = StIdle;
        else if (kind_q == KindConsume && hit_q) state_d = StCrd;
        else state_d = StOne;
      end
      StOne: if (out_free) state_d = StIdle;
      StCrd: state_d = cons_more ? StCuse : StCfin;
      StCuse: state_d = StCrd;
      StCfin: state_d = (n_q == '0) ? StOne : StEmit;
      StEmit: if (out_free && (EvCntW'(e_q) + 1'b1 == n_q)) state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  always_comb begin
    in_stall_o = state_q != StIdle;
    out_load = out_free && (state_q == StOne || state_q == StEmit);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      valid_q <= '0;
      next_id_q <= 32'd1;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (out_load) out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;
      if (cfg_we_i) next_id_q <= cfg_wdata_i;
      if (state_q == StLvl) begin
        if ((kind_q == KindNew || kind_q == KindChange) && (hit_q || avail_q))
          valid_q[lvl_q] <= 1'b1;
        if (kind_q == KindDelete && hit_q) valid_q[lvl_q] <= 1'b0;
        if (kind_q == KindAdd && (hit_q || avail_q) && !q_full) begin
          valid_q[lvl_q] <= 1'b1;
          next_id_q <= next_id_q + 32'd1;
        end
      end
      if (state_q == StCfin && cnt_q == '0) valid_q[lvl_q] <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    lvl_rd <= level_mem[state_q == StLook ? (hit_d ? hidx : fidx) : lvl_q];
    slot_rd <= slot_mem[{lvl_q, head_q}];
    if (state_q == StLvl && (hit_q || avail_q)) begin
      if (kind_q == KindNew || kind_q == KindChange)
        level_mem[lvl_q] <= '{sum: qty_q, head: lhead, cnt: lcnt};
      if (kind_q == KindAdd && !q_full) begin
        level_mem[lvl_q] <= '{sum: lsum + qty_q, head: lhead, cnt: lcnt + 1'b1};
        slot_mem[{lvl_q, lhead + lcnt[SlotW-1:0]}] <= '{id: next_id_q, qty: qty_q};
      end
    end
    if (state_q == StCuse && !take_all)
      slot_mem[{lvl_q, head_q}] <= '{id: slot_rd.id, qty: slot_rd.qty - rem_q};
    if (state_q == StCfin && cnt_q != '0)
      level_mem[lvl_q] <= '{sum: new_sum, head: head_q, cnt: cnt_q};
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      kind_q <= kind_i;
      price_q <= price_i;
      qty_q <= qty_i;
      etype_q <= event_type_i;
      ets_q <= exchange_ts_i;
      rts_q <= recv_ts_i;
      tid_q <= trade_id_i;
      for (int i = 0; i < NumLevels; i++) begin
        match_q[i] <= valid_q[i] && (key_q[i] == price_i);
      end
      free_q <= ~valid_q;
    end
    if (state_q == StLook) begin
      hit_q <= hit_d;
      avail_q <= avail_d;
      lvl_q <= hit_d ? hidx : fidx;
    end
    if (state_q == StLvl) begin
      res_delta_q <= '0;
      res_oid_q <= '0;
      res_total_q <= '0;
      res_present_q <= 1'b0;
      sum_q <= lsum;
      head_q <= lhead;
      cnt_q <= lcnt;
      rem_q <= qty_q;
      n_q <= '0;
      case (kind_q)
        KindNew, KindChange: begin
          if (hit_q || avail_q) begin
            key_q[lvl_q] <= price_q;
            res_kind_q <= ResDelta;
            res_delta_q <= {1'b0, qty_q} - {1'b0, lsum};
            res_total_q <= qty_q;
            res_present_q <= 1'b1;
          end else begin
            res_kind_q <= ResFull;
          end
        end
        KindDelete: begin
          res_kind_q <= ResDelta;
          if (hit_q) res_delta_q <= 33'd0 - {1'b0, lsum};
        end
        KindAdd: begin
          if (!(hit_q || avail_q)) begin
            res_kind_q <= ResFull;
          end else if (q_full) begin
            res_kind_q <= ResFull;
            res_total_q <= lsum;
            res_present_q <= 1'b1;
          end else begin
            key_q[lvl_q] <= price_q;
            res_kind_q <= ResOrderId;
            res_oid_q <= next_id_q;
            res_total_q <= lsum + qty_q;
            res_present_q <= 1'b1;
          end
        end
        default: res_kind_q <= ResNone;
      endcase
    end
    if (state_q == StCuse) begin
      ev_id_q[n_q[EvW-1:0]] <= slot_rd.id;
      ev_qty_q[n_q[EvW-1:0]] <= take_all ? slot_rd.qty : rem_q;
      n_q <= n_q + 1'b1;
      rem_q <= take_all ? rem_q - slot_rd.qty : '0;
      if (take_all) begin
        head_q <= head_q + 1'b1;
        cnt_q <= cnt_q - 1'b1;
      end
    end
    if (state_q == StCfin) begin
      res_kind_q <= ResNone;
      res_total_q <= (cnt_q == '0) ? '0 : new_sum;
      res_present_q <= cnt_q != '0;
      e_q <= '0;
    end
    if (out_load) begin
      level_total_o <= res_total_q;
      level_present_o <= res_present_q;
      if (state_q == StEmit) begin
        result_kind_o <= ResEvent;
        delta_o <= '0;
        order_id_o <= ev_id_q[e_q];
        event_price_o <= price_q;
        event_qty_o <= ev_qty_q[e_q];
        event_kind_o <= etype_q;
        event_exchange_ts_o <= ets_q;
        event_recv_ts_o <= rts_q;
        event_trade_id_o <= etype_q ? '0 : tid_q;
        last_o <= EvCntW'(e_q) + 1'b1 == n_q;
        e_q <= e_q + 1'b1;
      end else begin
        result_kind_o <= res_kind_q;
        delta_o <= res_delta_q;
        order_id_o <= res_oid_q;
        event_price_o <= '0;
        event_qty_o <= '0;
        event_kind_o <= 1'b0;
        event_exchange_ts_o <= '0;
        event_recv_ts_o <= '0;
        event_trade_id_o <= '0;
        last_o <= 1'b1;
      end
    end
  end

  a_unique_key: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == StLook |-> $onehot0(match_q)) else $error("duplicate level key");
  a_walk_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == StCuse |-> cnt_q != '0) else $error("walk on empty queue");
  a_emit_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == StEmit |-> EvCntW'(e_q) < n_q) else $error("event index out of range");
endmodule
`default_nettype wire
